>>> hdl/dmic_pkg.sv
// shared types and constants for the direct-mapped instruction cache
package dmic_pkg;

  localparam int unsigned LineBytesDefault  = 16;
  localparam int unsigned CacheBytesDefault = 16384;

  typedef enum logic [1:0] {
    OP_FETCH = 2'd0,
    OP_PROBE = 2'd1,
    OP_FILL  = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  // read and write strobes of one synchronous memory
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ram_req_t;

endpackage

>>> hdl/direct_mapped_instruction_cache.sv
// top level of the direct-mapped instruction cache
//
// Direct-mapped instruction cache, CACHE_BYTES bytes in LINE_BYTES-byte lines
// (16 KB, 1024 lines of 16 bytes by default). One item is accepted per cycle
// while in_stall_o is low: the tag/valid memory and the data memory are read
// at the transfer, the tag is compared in the following cycle and a miss
// writes the new tag back when its result enters the output register, with
// the pending tag write forwarded to the item read in the same cycle. The
// result enters the output register when stage 1 advances; a stalled result
// blocks the next input transfer only while stage 1 also holds an item.
// Fetches return 1, 2, 4 or 8 little-endian bytes aligned down to the size;
// probes and the reserved operation code only look up and claim the line;
// fills write one 64-bit word straight into the data memory at the transfer.
// After reset the valid bits are cleared in a pass over the CACHE_BYTES/LINE_BYTES
// lines (1024 by default), during which in_stall_o is held high.
module direct_mapped_instruction_cache #(
  parameter int unsigned LINE_BYTES  = dmic_pkg::LineBytesDefault,
  parameter int unsigned CACHE_BYTES = dmic_pkg::CacheBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [63:0] address_i,
  input  logic [3:0]  size_bytes_i,
  input  logic [63:0] fill_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [63:0] read_data_o,
  output logic        fill_request_o,
  output logic [63:0] fill_address_o
);

  localparam int unsigned NumLines = CACHE_BYTES / LINE_BYTES;
  localparam int unsigned OffBits  = $clog2(LINE_BYTES);
  localparam int unsigned IdxBits  = $clog2(NumLines);
  localparam int unsigned TagBits  = 64 - OffBits - IdxBits;
  localparam int unsigned DAddrBits = $clog2(CACHE_BYTES) - 3;

  // handshake
  logic accept, s1_adv;

  // stage 1: item whose memory reads are in flight
  logic                 s1_v_q;
  dmic_pkg::op_e        s1_op_q;
  logic [63:0]          s1_addr_q;
  logic [3:0]           s1_size_q;

  // tag write forwarded to the item read at the same edge
  logic                 fwd_v_q;
  logic [IdxBits-1:0]   fwd_idx_q;
  logic [TagBits-1:0]   fwd_tag_q;

  // output register
  logic                 out_v_q;
  logic                 hit_q, freq_q;
  logic [63:0]          rdata_q, faddr_q;

  dmic_pkg::ram_req_t   tag_req, data_req;
  dmic_pkg::op_e        in_op;
  logic                 tag_busy, rd_valid;
  logic [TagBits-1:0]   rd_tag;
  logic [63:0]          rd_word;

  logic [IdxBits-1:0]   s1_idx;
  logic [TagBits-1:0]   s1_tag;
  logic                 eff_valid, s1_lookup, s1_hit;
  logic [TagBits-1:0]   eff_tag;
  logic [2:0]           start;
  logic [63:0]          shifted, byte_mask, fetch_data;

  assign in_op  = dmic_pkg::op_e'(operation_i);
  assign s1_adv = s1_v_q && (!out_v_q || !out_stall_i);
  // no transfer while the valid bits are being cleared or stage 1 is blocked
  assign in_stall_o = tag_busy || (s1_v_q && !s1_adv);
  assign accept = in_valid_i && !in_stall_o;

  assign s1_idx = s1_addr_q[OffBits+IdxBits-1:OffBits];
  assign s1_tag = s1_addr_q[63:OffBits+IdxBits];

  // a miss claims the line when its result moves to the output register
  assign tag_req.rd_en  = accept;
  assign tag_req.wr_en  = s1_adv && s1_lookup && !s1_hit;
  // fills go to the data memory at the transfer, so later fetches read them
  assign data_req.rd_en = accept && (in_op != dmic_pkg::OP_FILL);
  assign data_req.wr_en = accept && (in_op == dmic_pkg::OP_FILL);

  dmic_tag_ram #(
    .LINE_BYTES  (LINE_BYTES),
    .CACHE_BYTES (CACHE_BYTES)
  ) u_tag_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (tag_req),
    .rd_idx_i   (address_i[OffBits+IdxBits-1:OffBits]),
    .wr_idx_i   (s1_idx),
    .wr_tag_i   (s1_tag),
    .rd_valid_o (rd_valid),
    .rd_tag_o   (rd_tag),
    .busy_o     (tag_busy)
  );

  dmic_data_ram #(
    .CACHE_BYTES (CACHE_BYTES)
  ) u_data_ram (
    .clk_i     (clk_i),
    .req_i     (data_req),
    .rd_addr_i (address_i[DAddrBits+2:3]),
    .wr_addr_i (address_i[DAddrBits+2:3]),
    .wr_data_i (fill_data_i),
    .rd_data_o (rd_word)
  );

  // tag compare with forwarding of the write that raced this item's read
  always_comb begin
    if (fwd_v_q && (fwd_idx_q == s1_idx)) begin
      eff_valid = 1'b1;
      eff_tag   = fwd_tag_q;
    end else begin
      eff_valid = rd_valid;
      eff_tag   = rd_tag;
    end
    s1_lookup = (s1_op_q != dmic_pkg::OP_FILL);
    s1_hit    = s1_lookup && eff_valid && (eff_tag == s1_tag);
  end

  // byte select within the 64-bit word, start aligned down to the size
  always_comb begin
    start   = s1_addr_q[2:0] & ~(s1_size_q[2:0] - 3'd1);
    shifted = rd_word >> {start, 3'b000};
    case (s1_size_q)
      4'd1:    byte_mask = 64'h0000_0000_0000_00FF;
      4'd2:    byte_mask = 64'h0000_0000_0000_FFFF;
      4'd4:    byte_mask = 64'h0000_0000_FFFF_FFFF;
      4'd8:    byte_mask = 64'hFFFF_FFFF_FFFF_FFFF;
      default: byte_mask = '0;
    endcase
    fetch_data = (s1_hit && (s1_op_q == dmic_pkg::OP_FETCH)) ? (shifted & byte_mask) : '0;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      fwd_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_q  <= 1'b1;
        fwd_v_q <= tag_req.wr_en;
      end else if (s1_adv) begin
        s1_v_q  <= 1'b0;
      end
      if (s1_adv) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= in_op;
      s1_addr_q <= address_i;
      s1_size_q <= size_bytes_i;
      fwd_idx_q <= s1_idx;
      fwd_tag_q <= s1_tag;
    end
    if (s1_adv) begin
      hit_q   <= s1_hit;
      rdata_q <= fetch_data;
      freq_q  <= s1_lookup && !s1_hit;
      faddr_q <= (s1_lookup && !s1_hit) ? {s1_addr_q[63:OffBits], {OffBits{1'b0}}} : '0;
    end
  end

  assign out_valid_o    = out_v_q;
  assign hit_o          = hit_q;
  assign read_data_o    = rdata_q;
  assign fill_request_o = freq_q;
  assign fill_address_o = faddr_q;

`ifndef SYNTHESIS
  a_no_transfer_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_busy |-> in_stall_o)
    else $error("input transfer during valid clear");

  a_hit_xor_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && fill_request_o))
    else $error("hit and fill request together");

  a_data_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (read_data_o != 64'd0)) |-> hit_o)
    else $error("read data without hit");

  a_faddr_only_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !fill_request_o) |-> (fill_address_o == 64'd0))
    else $error("fill address without request");

  a_stage1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s1_adv) |=> (s1_v_q && $stable(s1_addr_q)))
    else $error("blocked stage 1 item lost");
`endif

endmodule

>>> hdl/dmic_tag_ram.sv
// tag and valid memory with a clearing pass after reset
module dmic_tag_ram #(
  parameter int unsigned LINE_BYTES  = dmic_pkg::LineBytesDefault,
  parameter int unsigned CACHE_BYTES = dmic_pkg::CacheBytesDefault,
  localparam int unsigned NumLines   = CACHE_BYTES / LINE_BYTES,
  localparam int unsigned OffBits    = $clog2(LINE_BYTES),
  localparam int unsigned IdxBits    = $clog2(NumLines),
  localparam int unsigned TagBits    = 64 - OffBits - IdxBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dmic_pkg::ram_req_t    req_i,
  input  logic [IdxBits-1:0]    rd_idx_i,
  input  logic [IdxBits-1:0]    wr_idx_i,
  input  logic [TagBits-1:0]    wr_tag_i,
  output logic                  rd_valid_o,
  output logic [TagBits-1:0]    rd_tag_o,
  output logic                  busy_o
);

  logic [TagBits:0]   mem [NumLines];
  logic [TagBits:0]   rd_q;
  logic               busy_q, busy_d;
  logic [IdxBits-1:0] clr_q, clr_d;
  logic               we;
  logic [IdxBits-1:0] wa;
  logic [TagBits:0]   wd;

  always_comb begin
    busy_d = busy_q;
    clr_d  = clr_q;
    if (busy_q) begin
      clr_d = clr_q + 1'b1;
      if (clr_q == IdxBits'(NumLines - 1)) begin
        busy_d = 1'b0;
      end
    end
    we = busy_q || req_i.wr_en;
    wa = busy_q ? clr_q : wr_idx_i;
    wd = busy_q ? '0 : {1'b1, wr_tag_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      clr_q  <= clr_d;
    end
  end

  // read before write on the same address
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[rd_idx_i];
    end
  end

  assign rd_valid_o = rd_q[TagBits];
  assign rd_tag_o   = rd_q[TagBits-1:0];
  assign busy_o     = busy_q;

endmodule

>>> hdl/dmic_data_ram.sv
// line data memory organized as 64-bit words
module dmic_data_ram #(
  parameter int unsigned CACHE_BYTES = dmic_pkg::CacheBytesDefault,
  localparam int unsigned AddrBits   = $clog2(CACHE_BYTES) - 3
) (
  input  logic                 clk_i,
  input  dmic_pkg::ram_req_t   req_i,
  input  logic [AddrBits-1:0]  rd_addr_i,
  input  logic [AddrBits-1:0]  wr_addr_i,
  input  logic [63:0]          wr_data_i,
  output logic [63:0]          rd_data_o
);

  logic [63:0] mem [2**AddrBits];
  logic [63:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> bench/direct_mapped_instruction_cache_tb.sv
// self-checking testbench for the direct-mapped instruction cache
module direct_mapped_instruction_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // cache geometry, taken from the block's defaults
  localparam int unsigned LINE_B    = dmic_pkg::LineBytesDefault;
  localparam int unsigned CACHE_B   = dmic_pkg::CacheBytesDefault;
  localparam int unsigned NUM_LINES = CACHE_B / LINE_B;
  localparam int unsigned WORDS     = LINE_B / 8;
  localparam int unsigned OFF_W     = $clog2(LINE_B);
  localparam int unsigned IDX_W     = $clog2(NUM_LINES);
  localparam int unsigned TAG_W     = 64 - OFF_W - IDX_W;
  localparam int unsigned WRD_W     = (WORDS > 1) ? $clog2(WORDS) : 1;

  // run shape
  localparam time         CLK_PERIOD   = 10ns;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned NUM_DIRECTED = 25;
  localparam int unsigned DIR_W        = $clog2(NUM_DIRECTED);
  localparam int unsigned NUM_RANDOM   = 1600;
  localparam int unsigned TAIL_ITEMS   = 200;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned MAX_REPORTS  = 60;

  // one input transfer
  typedef struct packed {
    dmic_pkg::op_e op;
    logic [63:0]   addr;
    logic [3:0]    size;
    logic [63:0]   data;
  } access_t;

  // one result transfer
  typedef struct packed {
    logic        hit;
    logic [63:0] rdata;
    logic        freq;
    logic [63:0] faddr;
  } lookup_t;

  // directed rows either carry their result or leave it to the cache model
  typedef enum bit {BY_MODEL, BY_TABLE} check_src_e;

  typedef struct packed {
    access_t    acc;
    check_src_e src;
    lookup_t    want;
  } stim_row_t;

  localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam lookup_t NO_RESULT = '0;

  // directed part: cold miss, refill, every fetch width, the eight-byte one in
  // both words of the line, unsupported widths, probe and the reserved code on
  // hit and miss, the top of the address space, a conflict eviction and a hit
  // that reads the line's earlier content before its refill
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{dmic_pkg::OP_FETCH, 64'h0, 4'd8, 64'h0}, BY_TABLE,
      '{1'b0, 64'h0, 1'b1, 64'h0}},
    '{'{dmic_pkg::OP_FILL, 64'h0, 4'd0, 64'h0706_0504_0302_0100}, BY_TABLE, NO_RESULT},
    '{'{dmic_pkg::OP_FILL, 64'hF, 4'd0, 64'h0F0E_0D0C_0B0A_0908}, BY_TABLE, NO_RESULT},
    '{'{dmic_pkg::OP_FETCH, 64'h6, 4'd8, 64'h0}, BY_MODEL, NO_RESULT},
    '{'{dmic_pkg::OP_FETCH, 64'hF, 4'd1, 64'h0}, BY_MODEL, NO_RESULT},
    '{'{dmic_pkg::OP_FETCH, 64'hB, 4'd2, 64'h0}, BY_MODEL, NO_RESULT},
    '{'{dmic_pkg::OP_FETCH, 64'hD, 4'd4, 64'h0}, BY_MODEL, NO_RESULT},
    '{'{dmic_pkg::OP_FETCH, 64'h9, 4'd8, 64'h0}, BY_MODEL, NO_RESULT},
    '{'{dmic_pkg::OP_FETCH, 64'h3, 4'd3, 64'h0}, BY_TABLE,
      '{1'b1, 64'h0, 1'b0, 64'h0}},
    '{'{dmic_pkg::OP_FETCH, 64'h0, 4'd0, 64'h0}, BY_TABLE,
      '{1'b1, 64'h0, 1'b0, 64'h0}},
    '{'{dmic_pkg::OP_FETCH, 64'h8, 4'd15, ALL1}, BY_TABLE,
      '{1'b1, 64'h0, 1'b0, 64'h0}},
    '{'{dmic_pkg::OP_PROBE, 64'h4, 4'd8, 64'h0}, BY_TABLE,
      '{1'b1, 64'h0, 1'b0, 64'h0}},
    '{'{dmic_pkg::OP_RSVD, 64'h4, 4'd1, 64'h0}, BY_TABLE,
      '{1'b1, 64'h0, 1'b0, 64'h0}},
    '{'{dmic_pkg::OP_PROBE, ALL1, 4'd8, 64'h0}, BY_TABLE,
      '{1'b0, 64'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0}},
    '{'{dmic_pkg::OP_RSVD, 64'hFFFF_FFFF_FFFF_FFE5, 4'd4, 64'h0}, BY_TABLE,
      '{1'b0, 64'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFE0}},
    '{'{dmic_pkg::OP_FILL, 64'hFFFF_FFFF_FFFF_FFF3, 4'd0, ALL1}, BY_TABLE, NO_RESULT},
    '{'{dmic_pkg::OP_FILL, ALL1, 4'd0, 64'h8000_0000_0000_0001}, BY_TABLE, NO_RESULT},
    '{'{dmic_pkg::OP_FETCH, ALL1, 4'd1, 64'h0}, BY_TABLE,
      '{1'b1, 64'h80, 1'b0, 64'h0}},
    '{'{dmic_pkg::OP_FETCH, 64'hFFFF_FFFF_FFFF_FFF8, 4'd8, 64'h0}, BY_TABLE,
      '{1'b1, 64'h8000_0000_0000_0001, 1'b0, 64'h0}},
    '{'{dmic_pkg::OP_FETCH, 64'hFFFF_FFFF_FFFF_FFF4, 4'd4, 64'h0}, BY_TABLE,
      '{1'b1, 64'hFFFF_FFFF, 1'b0, 64'h0}},
    '{'{dmic_pkg::OP_FETCH, 64'h4000, 4'd4, 64'h0}, BY_TABLE,
      '{1'b0, 64'h0, 1'b1, 64'h4000}},
    '{'{dmic_pkg::OP_PROBE, 64'h0, 4'd2, 64'h0}, BY_TABLE,
      '{1'b0, 64'h0, 1'b1, 64'h0}},
    '{'{dmic_pkg::OP_FETCH, 64'h0, 4'd8, 64'h0}, BY_MODEL, NO_RESULT},
    '{'{dmic_pkg::OP_FILL, 64'h4005, 4'd15, 64'hA5A5_5A5A_C3C3_3C3C}, BY_MODEL, NO_RESULT},
    '{'{dmic_pkg::OP_FETCH, 64'h2, 4'd2, 64'h0}, BY_MODEL, NO_RESULT}
  };

  // clock, reset and block ports
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = dmic_pkg::OP_FETCH;
  logic [63:0] address_i = '0;
  logic [3:0]  size_bytes_i = '0;
  logic [63:0] fill_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        hit_o;
  logic [63:0] read_data_o;
  logic        fill_request_o;
  logic [63:0] fill_address_o;

  // cache model state: valid bits clear from reset, data tracked per word so
  // that a fetch never reads a word nobody has filled
  bit               line_valid  [NUM_LINES];
  bit [TAG_W-1:0]   line_tag    [NUM_LINES];
  bit [7:0]         line_data   [NUM_LINES][LINE_B];
  bit               word_filled [NUM_LINES][WORDS];

  // address pools that make hits, refills and conflict misses common
  logic [TAG_W-1:0] tag_pool [4];
  logic [IDX_W-1:0] idx_pool [8];

  lookup_t     pending_results [$];  // results owed by the cache, oldest first
  access_t     access_plan [$];      // random transfers queued for the driver
  access_t     cur_acc;              // transfer on the input port
  check_src_e  cur_src;
  lookup_t     cur_want;
  bit          holding = 1'b0;       // cur_acc offered and not yet taken
  bit          stim_done = 1'b0;
  bit          calm = 1'b0;          // stretch without any idling
  int unsigned dir_ptr = 0;
  int unsigned rand_cnt = 0;
  int unsigned gap_cnt = 0;
  int unsigned stall_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  direct_mapped_instruction_cache uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .address_i      (address_i),
    .size_bytes_i   (size_bytes_i),
    .fill_data_i    (fill_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .read_data_o    (read_data_o),
    .fill_request_o (fill_request_o),
    .fill_address_o (fill_address_o)
  );

  function automatic bit size_ok(logic [3:0] s);
    return s == 4'd1 || s == 4'd2 || s == 4'd4 || s == 4'd8;
  endfunction

  // line is valid and holds this address's tag
  function automatic bit resident(logic [63:0] addr);
    logic [IDX_W-1:0] idx;
    idx = addr[OFF_W +: IDX_W];
    return line_valid[idx] && line_tag[idx] == addr[63 -: TAG_W];
  endfunction

  // cache behavior for one transfer, updating the model state in order
  function automatic lookup_t cache_lookup(access_t a);
    lookup_t          r;
    logic [IDX_W-1:0] idx;
    logic [WRD_W-1:0] w;
    int unsigned      off, start, sz;
    logic [TAG_W-1:0] tg;
    r   = '0;
    idx = a.addr[OFF_W +: IDX_W];
    off = 32'(a.addr[OFF_W-1:0]);
    tg  = a.addr[63 -: TAG_W];
    sz  = 32'(a.size);
    if (a.op == dmic_pkg::OP_FILL) begin
      // fill writes one word, tag and valid untouched
      w = WRD_W'((off / 8) % WORDS);
      for (int k = 0; k < 8; k++) line_data[idx][OFF_W'(w * 8 + k)] = a.data[8 * k +: 8];
      word_filled[idx][w] = 1'b1;
    end else if (line_valid[idx] && line_tag[idx] == tg) begin
      r.hit = 1'b1;
      // only fetches of a supported width return bytes, aligned down
      if (a.op == dmic_pkg::OP_FETCH && size_ok(a.size)) begin
        start = off & ~(sz - 1);
        for (int k = 0; k < sz; k++)
          r.rdata[8 * k +: 8] = line_data[idx][OFF_W'(start + k)];
      end
    end else begin
      // any non-fill miss claims the line and asks for its refill
      line_valid[idx] = 1'b1;
      line_tag[idx]   = tg;
      r.freq  = 1'b1;
      r.faddr = {a.addr[63:OFF_W], {OFF_W{1'b0}}};
    end
    return r;
  endfunction

  // a fetch hitting a word never filled would read undefined data:
  // turn it into a probe or an unsupported width instead
  function automatic access_t legalize(access_t a);
    logic [IDX_W-1:0] idx;
    logic [WRD_W-1:0] w;
    idx = a.addr[OFF_W +: IDX_W];
    w   = WRD_W'((int'(a.addr[OFF_W-1:0]) / 8) % WORDS);
    if (a.op == dmic_pkg::OP_FETCH && size_ok(a.size) && resident(a.addr) &&
        !word_filled[idx][w]) begin
      if ($urandom_range(0, 1) == 0) begin
        a.op = dmic_pkg::OP_PROBE;
      end else begin
        do a.size = 4'($urandom_range(0, 15)); while (size_ok(a.size));
      end
    end
    return a;
  endfunction

  function automatic logic [63:0] pick_address();
    logic [63:0] a;
    a = {$urandom, $urandom};
    if ($urandom_range(0, 4) != 0) a[63 -: TAG_W] = tag_pool[2'($urandom_range(0, 3))];
    if ($urandom_range(0, 1) != 0) a[OFF_W +: IDX_W] = idx_pool[3'($urandom_range(0, 7))];
    return a;
  endfunction

  // mostly the supported widths, now and then any 4-bit value
  function automatic logic [3:0] pick_size();
    if ($urandom_range(0, 99) < 85) return 4'(1 << $urandom_range(0, 3));
    return 4'($urandom_range(0, 15));
  endfunction

  // queue one burst: a stray transfer, a miss with a partial refill, or the
  // normal sequence of fetch, refill of the whole line and follow-up hits
  task automatic plan_burst();
    access_t     a;
    logic [63:0] base;
    bit          was_resident;
    int unsigned kind, n_fill, first_w, w, r;
    kind = $urandom_range(0, 99);
    a.addr = pick_address();
    a.data = {$urandom, $urandom};
    a.size = 4'($urandom_range(0, 15));
    base = {a.addr[63:OFF_W], {OFF_W{1'b0}}};
    if (kind < 15) begin
      a.op = dmic_pkg::op_e'($urandom_range(0, 3));
      access_plan.push_back(a);
    end else begin
      was_resident = resident(a.addr);
      a.op   = dmic_pkg::OP_FETCH;
      a.size = pick_size();
      access_plan.push_back(a);
      if (!was_resident || $urandom_range(0, 9) == 0) begin
        // broken sequences leave one word of the line unfilled
        n_fill  = (kind < 25) ? 1 : WORDS;
        first_w = $urandom_range(0, WORDS - 1);
        for (int k = 0; k < n_fill; k++) begin
          w      = (first_w + k) % WORDS;
          a.op   = dmic_pkg::OP_FILL;
          a.addr = base | 64'(w * 8 + $urandom_range(0, 7));
          a.data = {$urandom, $urandom};
          a.size = 4'($urandom_range(0, 15));
          access_plan.push_back(a);
        end
      end
      repeat ($urandom_range(1, 6)) begin
        r      = $urandom_range(0, 99);
        a.op   = (r < 80) ? dmic_pkg::OP_FETCH :
                 (r < 90) ? dmic_pkg::OP_PROBE : dmic_pkg::OP_RSVD;
        a.addr = base | 64'($urandom_range(0, LINE_B - 1));
        a.size = pick_size();
        a.data = {$urandom, $urandom};
        access_plan.push_back(a);
      end
    end
  endtask

  task automatic take_next_access(output bit ok);
    stim_row_t row;
    ok = 1'b1;
    if (dir_ptr < NUM_DIRECTED) begin
      row      = directed_rows[DIR_W'(dir_ptr)];
      cur_acc  = row.acc;
      cur_src  = row.src;
      cur_want = row.want;
      dir_ptr++;
    end else if (rand_cnt < NUM_RANDOM) begin
      if (access_plan.size() == 0) plan_burst();
      cur_acc = legalize(access_plan.pop_front());
      cur_src = BY_MODEL;
      rand_cnt++;
    end else begin
      ok = 1'b0;
    end
  endtask

  task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $error("%s: expected %h, actual %h", field, want, got);
  endtask

  // compare one result transfer with the oldest expectation
  task automatic check_result();
    lookup_t want;
    if (pending_results.size() == 0) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $error("result with nothing expected: hit %b read_data %h fill_request %b",
               hit_o, read_data_o, fill_request_o);
    end else begin
      want = pending_results.pop_front();
      if (hit_o !== want.hit) report_mismatch("hit", 64'(want.hit), 64'(hit_o));
      if (read_data_o !== want.rdata) report_mismatch("read_data", want.rdata, read_data_o);
      if (fill_request_o !== want.freq)
        report_mismatch("fill_request", 64'(want.freq), 64'(fill_request_o));
      if (fill_address_o !== want.faddr)
        report_mismatch("fill_address", want.faddr, fill_address_o);
    end
  endtask

  // called at each clock edge: values read here are the ones from before the edge,
  // new drive values go out as nonblocking updates
  task automatic step();
    bit      in_fire, out_fire, idle_on, ok;
    lookup_t want;
    in_fire  = in_valid_i && !in_stall_o;
    out_fire = out_valid_o && !out_stall_i;
    if ($urandom_range(0, 127) == 0) calm = !calm;
    idle_on = !calm && rand_cnt < NUM_RANDOM - TAIL_ITEMS;

    if (in_fire) begin
      // model always runs so its state follows the cache, table rows override
      want = cache_lookup(cur_acc);
      if (cur_src == BY_TABLE) want = cur_want;
      pending_results.push_back(want);
      holding = 1'b0;
      if (idle_on && $urandom_range(0, 5) == 0) gap_cnt = $urandom_range(1, 8);
    end
    if (out_fire) check_result();

    // result side back-pressure in bursts
    if (!idle_on) begin
      stall_cnt = 0;
      out_stall_i <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_cnt = $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end

    // input side: hold an offered transfer, else gap or offer the next one
    if (!holding) begin
      if (gap_cnt > 0) begin
        gap_cnt--;
        in_valid_i <= 1'b0;
      end else begin
        take_next_access(ok);
        if (ok) begin
          holding = 1'b1;
          operation_i  <= cur_acc.op;
          address_i    <= cur_acc.addr;
          size_bytes_i <= cur_acc.size;
          fill_data_i  <= cur_acc.data;
          in_valid_i   <= 1'b1;
        end else begin
          stim_done = 1'b1;
          in_valid_i <= 1'b0;
        end
      end
    end
  endtask

  initial begin : run
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    tag_pool[2] = TAG_W'({$urandom, $urandom});
    tag_pool[3] = TAG_W'({$urandom, $urandom});
    idx_pool[0] = '0;
    idx_pool[1] = IDX_W'(NUM_LINES - 1);
    for (int k = 2; k < 8; k++) idx_pool[3'(k)] = IDX_W'($urandom_range(0, NUM_LINES - 1));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // the valid-clearing pass after reset shows up as input stall
    while (!(stim_done && !holding && pending_results.size() == 0)) begin
      @(posedge clk_i);
      step();
    end
    // watch for stray results after the last one
    repeat (DRAIN_CYCLES) begin
      @(posedge clk_i);
      step();
    end

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
